// ===== design/sfrx_pkg.sv =====
`default_nettype none

package sfrx_pkg;

    localparam int MAX_FRAME_BYTES = 64;
    localparam int ADDR_W          = $clog2(MAX_FRAME_BYTES);
    localparam int CNT_W           = ADDR_W + 1;

    localparam logic [7:0] MIN_LEN    = 8'd2;
    localparam logic [7:0] MAX_LEN    = 8'(MAX_FRAME_BYTES - 2);
    localparam logic [7:0] CRC_POLY   = 8'hD5;
    localparam logic [7:0] SYNC_RESET = 8'hEA;
    localparam logic [7:0] ERR_BYTE   = 8'h00;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start_frame;
        logic take_len;
        logic store_byte;
        logic rd_start;
        logic rd_issue;
        logic load_data;
        logic load_err;
    } t_dp_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic is_sync;
        logic len_ok;
        logic is_crc_byte;
        logic crc_ok;
        logic out_free;
        logic rd_last;
    } t_dp_stat;

    // One byte folded into the CRC, most significant bit first.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== design/sfrx_ctrl.sv =====
`default_nettype none

module sfrx_ctrl
    import sfrx_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_rx_valid,
    output logic          o_rx_stall,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_SYNC,
        S_LEN,
        S_DATA,
        S_ERR,
        S_RD,
        S_LOAD
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SYNC;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_rx_stall = 1'b1;
        case (r_state)
            S_SYNC: begin
                o_rx_stall = 1'b0;
                if (i_rx_valid && i_stat.is_sync) begin
                    o_cmd.start_frame = 1'b1;
                    n_state           = S_LEN;
                end
            end
            S_LEN: begin
                o_rx_stall = 1'b0;
                if (i_rx_valid) begin
                    if (i_stat.len_ok) begin
                        o_cmd.take_len = 1'b1;
                        n_state        = S_DATA;
                    end else begin
                        n_state = S_ERR;
                    end
                end
            end
            S_DATA: begin
                o_rx_stall = 1'b0;
                if (i_rx_valid) begin
                    if (!i_stat.is_crc_byte) begin
                        o_cmd.store_byte = 1'b1;
                    end else if (i_stat.crc_ok) begin
                        o_cmd.rd_start = 1'b1;
                        n_state        = S_RD;
                    end else begin
                        n_state = S_ERR;
                    end
                end
            end
            S_ERR: begin
                if (i_stat.out_free) begin
                    o_cmd.load_err = 1'b1;
                    n_state        = S_SYNC;
                end
            end
            S_RD: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_LOAD;
            end
            S_LOAD: begin
                if (i_stat.out_free) begin
                    o_cmd.load_data = 1'b1;
                    n_state         = i_stat.rd_last ? S_SYNC : S_RD;
                end
            end
            default: begin
                n_state = S_SYNC;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/sfrx_dp.sv =====
`default_nettype none

module sfrx_dp
    import sfrx_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_sync_byte,
    input  wire logic       i_frame_stall,
    output logic            o_frame_valid,
    output logic [7:0]      o_frame_byte,
    input  wire t_dp_cmd    i_cmd,
    output t_dp_stat        o_stat
);

    logic [7:0]        r_sync;
    logic [CNT_W-1:0]  r_len;
    logic [CNT_W-1:0]  r_cnt;
    logic [7:0]        r_crc;
    logic [ADDR_W-1:0] r_rd_ptr;
    logic [7:0]        r_rd_data;
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic [7:0]        r_store [MAX_FRAME_BYTES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync <= SYNC_RESET;
        end else if (i_cfg_we) begin
            r_sync <= i_cfg_sync_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_cnt <= '0;
            r_crc <= '0;
        end else begin
            if (i_cmd.start_frame) begin
                r_len <= '0;
                r_cnt <= '0;
                r_crc <= '0;
            end
            if (i_cmd.take_len) begin
                r_len <= i_rx_byte[CNT_W-1:0];
            end
            if (i_cmd.store_byte) begin
                r_cnt <= r_cnt + CNT_W'(1);
                r_crc <= crc8_update(r_crc, i_rx_byte);
            end
        end
    end

    // Frame store: written one beat at a time, read back with a registered port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_byte) begin
            r_store[r_cnt[ADDR_W-1:0]] <= i_rx_byte;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_store[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_start) begin
            r_rd_ptr <= '0;
        end else if (i_cmd.load_data) begin
            r_rd_ptr <= r_rd_ptr + ADDR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_data || i_cmd.load_err) begin
            r_out_valid <= 1'b1;
        end else if (!i_frame_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_data) begin
            r_out_byte <= r_rd_data;
        end else if (i_cmd.load_err) begin
            r_out_byte <= ERR_BYTE;
        end
    end

    assign o_frame_valid = r_out_valid;
    assign o_frame_byte  = r_out_byte;

    always_comb begin
        o_stat.is_sync     = (i_rx_byte == r_sync);
        o_stat.len_ok      = (i_rx_byte >= MIN_LEN) && (i_rx_byte <= MAX_LEN);
        o_stat.is_crc_byte = ((r_cnt + CNT_W'(1)) == r_len);
        o_stat.crc_ok      = (i_rx_byte == r_crc);
        o_stat.out_free    = !r_out_valid || !i_frame_stall;
        o_stat.rd_last     = ((CNT_W'(r_rd_ptr) + CNT_W'(2)) == r_len);
    end

    a_store_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.store_byte |-> ((r_cnt + CNT_W'(1)) < r_len))
        else $error("frame store written beyond the frame length");

    a_read_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_data |-> ((CNT_W'(r_rd_ptr) + CNT_W'(2)) <= r_len))
        else $error("drain pointer ran past the stored bytes");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take_len |=> ((8'(r_len) >= MIN_LEN) && (8'(r_len) <= MAX_LEN)))
        else $error("frame length taken out of range");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_frame_stall) |-> !(i_cmd.load_data || i_cmd.load_err))
        else $error("output register loaded while its beat is stalled");

endmodule

`default_nettype wire

// ===== design/serial_frame_receiver_crc8.sv =====
`default_nettype none

// Serial frame receiver with CRC-8 (polynomial 0xD5) check. While waiting for a
// frame, one received byte is taken per cycle and dropped unless it matches the
// sync byte register; the length byte and each type, payload and CRC byte are
// also taken at one per cycle. Once the CRC byte matches, the stored type and
// payload bytes are read back from a 64-entry frame store with a registered
// read port and delivered one by one (a store read, then a load of the output
// register once it is free), so a frame of length L gives L-1 bytes. A
// length byte outside 2..62 or a CRC mismatch gives a single zero byte. The
// input is stalled while results are being delivered. The sync register may be
// rewritten at any time the block is idle; its write port is always ready.
module serial_frame_receiver_crc8
    import sfrx_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [7:0] i_cfg_sync_byte,
    input  wire logic       i_rx_valid,
    output logic            o_rx_stall,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_frame_valid,
    input  wire logic       i_frame_stall,
    output logic [7:0]      o_frame_byte
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    assign o_cfg_ready = 1'b1;

    sfrx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .o_rx_stall (o_rx_stall),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    sfrx_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rx_byte       (i_rx_byte),
        .i_cfg_we        (i_cfg_valid && o_cfg_ready),
        .i_cfg_sync_byte (i_cfg_sync_byte),
        .i_frame_stall   (i_frame_stall),
        .o_frame_valid   (o_frame_valid),
        .o_frame_byte    (o_frame_byte),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat)
    );

endmodule

`default_nettype wire
